@@ hdl/mcvt_pkg.sv @@
// ----------------------------------------------------------------------------
// mcvt_pkg: shared types and constants for the matrix and vertex unit
// Word format, accumulator sizing, operation codes and sequencer states.
// ----------------------------------------------------------------------------
package mcvt_pkg;

  localparam int FIELD_BITS = 32;
  localparam int WORD_BITS  = 32;
  localparam int FRAC_BITS  = 16;
  localparam int PROD_BITS  = 2 * WORD_BITS;
  localparam int ACC_BITS   = PROD_BITS + 2;
  localparam int CNT_BITS   = 6;

  localparam logic [CNT_BITS-1:0] VTX_LAST = CNT_BITS'(11);
  localparam logic [CNT_BITS-1:0] MAT_LAST = CNT_BITS'(63);

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;
  typedef logic signed [ACC_BITS-1:0]  acc_t;

  localparam word_t WORD_ONE = word_t'(1) <<< FRAC_BITS;
  localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  typedef enum logic [2:0] {
    OP_LOAD_CUR = 3'd0,
    OP_LOAD_OPD = 3'd1,
    OP_LEFT     = 3'd2,
    OP_RIGHT    = 3'd3,
    OP_VERTEX   = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_e;

endpackage

@@ hdl/matrix_compose_and_vertex_transform.sv @@
// ----------------------------------------------------------------------------
// matrix_compose_and_vertex_transform: 4x4 Q16.16 matrix compose and transform
// Holds a current and an operand matrix, composes them and transforms vertices
// through one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Each input beat carries an operation, a matrix entry index and value, and a
// vertex. Entry loads complete at the accepting edge and the block is ready
// again in the next cycle. A compose (left or right multiply) runs 64 terms
// through the single 32x32 multiplier and accumulator, one term per cycle, and
// the next beat is accepted only once it has finished. A vertex transform runs
// 12 terms (three rows of three products plus translation), and the block is
// ready again in the same cycle as its result shows at the output. Products
// are registered before they are accumulated, and each finished sum is
// shifted back to Q16.16 and clamped to a word. Compose results
// go to a second bank of the current matrix, so every product reads the old
// values. Reset makes the current matrix the identity and the operand matrix
// zero, and empties the output register. The output register holds a vertex
// result while the receiver stalls; loads and composes are still accepted
// meanwhile, and a finished vertex waits in the block until the output
// register is free.
// ----------------------------------------------------------------------------
module matrix_compose_and_vertex_transform (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [2:0]                        operation_i,
  input  logic [1:0]                        row_i,
  input  logic [1:0]                        col_i,
  input  logic signed [mcvt_pkg::FIELD_BITS-1:0] entry_value_i,
  input  logic signed [mcvt_pkg::FIELD_BITS-1:0] vert_x_i,
  input  logic signed [mcvt_pkg::FIELD_BITS-1:0] vert_y_i,
  input  logic signed [mcvt_pkg::FIELD_BITS-1:0] vert_z_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [mcvt_pkg::FIELD_BITS-1:0] out_x_o,
  output logic signed [mcvt_pkg::FIELD_BITS-1:0] out_y_o,
  output logic signed [mcvt_pkg::FIELD_BITS-1:0] out_z_o,
  output logic                              saturated_o
);
  import mcvt_pkg::*;

  state_e state_q, state_d;
  logic [2:0] op_q;
  logic [CNT_BITS-1:0] cnt_q;
  logic iss_done_q;
  logic bank_q;
  word_t cur_q [2][16];
  word_t opd_q [16];
  word_t vx_q, vy_q, vz_q;

  logic pv_q, pfirst_q, plast_q, pfin_q;
  logic [3:0] pidx_q;
  prod_t p_q;

  logic av_q, afin_q;
  logic [3:0] aidx_q;
  acc_t acc_q;

  word_t wx_q, wy_q, wz_q;
  logic wsat_q;
  logic ov_q;
  word_t ox_q, oy_q, oz_q;
  logic osat_q;

  logic in_acc, iss, fin, push, is_vtx, is_mat;
  logic [1:0] k;
  logic [3:0] ik, kj, c_addr, p_addr;
  logic [CNT_BITS-1:0] last_cnt;
  word_t c_rd, p_rd, opa, opb, vk, res;
  prod_t prod;
  acc_t acc_sh;
  logic clamp;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_vtx     = (op_q == OP_VERTEX);
  assign is_mat     = (op_q == OP_LEFT) || (op_q == OP_RIGHT);
  assign last_cnt   = is_vtx ? VTX_LAST : MAT_LAST;
  assign iss        = (state_q == ST_RUN) && !iss_done_q;
  assign fin        = av_q && afin_q;

  assign k      = cnt_q[1:0];
  assign ik     = {cnt_q[5:4], cnt_q[1:0]};
  assign kj     = {cnt_q[1:0], cnt_q[3:2]};
  assign c_addr = (op_q == OP_LEFT) ? kj : (is_vtx ? cnt_q[3:0] : ik);
  assign p_addr = (op_q == OP_LEFT) ? ik : kj;
  assign c_rd   = cur_q[bank_q][c_addr];
  assign p_rd   = opd_q[p_addr];

  always_comb begin
    case (k)
      2'd0:    vk = vx_q;
      2'd1:    vk = vy_q;
      2'd2:    vk = vz_q;
      default: vk = WORD_ONE;
    endcase
  end

  assign opa  = (op_q == OP_LEFT) ? p_rd : c_rd;
  assign opb  = (op_q == OP_LEFT) ? c_rd : ((op_q == OP_RIGHT) ? p_rd : vk);
  assign prod = opa * opb;

  assign acc_sh = acc_q >>> FRAC_BITS;
  assign clamp  = !((&acc_sh[ACC_BITS-1:WORD_BITS-1]) || !(|acc_sh[ACC_BITS-1:WORD_BITS-1]));
  assign res    = clamp ? (acc_sh[ACC_BITS-1] ? WORD_MIN : WORD_MAX)
                        : acc_sh[WORD_BITS-1:0];

  always_comb begin
    state_d = state_q;
    push    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (operation_i == OP_LEFT || operation_i == OP_RIGHT ||
                       operation_i == OP_VERTEX)) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (fin) begin
          state_d = is_vtx ? ST_HOLD : ST_IDLE;
        end
      end
      ST_HOLD: begin
        if (!ov_q || !out_stall_i) begin
          push    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q <= 1'b0;
      for (int b = 0; b < 2; b++) begin
        for (int i = 0; i < 16; i++) begin
          cur_q[b][i] <= (i == 0 || i == 5 || i == 10 || i == 15) ? WORD_ONE : '0;
        end
      end
      for (int i = 0; i < 16; i++) begin
        opd_q[i] <= '0;
      end
    end else begin
      if (in_acc && operation_i == OP_LOAD_CUR) begin
        cur_q[bank_q][{row_i, col_i}] <= WORD_BITS'(entry_value_i);
      end
      if (in_acc && operation_i == OP_LOAD_OPD) begin
        opd_q[{row_i, col_i}] <= WORD_BITS'(entry_value_i);
      end
      if (av_q && is_mat) begin
        cur_q[!bank_q][aidx_q] <= res;
      end
      if (fin && is_mat) begin
        bank_q <= !bank_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_done_q <= 1'b0;
      cnt_q      <= '0;
      pv_q       <= 1'b0;
      av_q       <= 1'b0;
      ov_q       <= 1'b0;
    end else begin
      if (in_acc) begin
        cnt_q      <= '0;
        iss_done_q <= 1'b0;
      end else if (iss) begin
        cnt_q      <= cnt_q + CNT_BITS'(1);
        iss_done_q <= (cnt_q == last_cnt);
      end
      pv_q <= iss;
      av_q <= pv_q && plast_q;
      if (push) begin
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= operation_i;
      vx_q   <= WORD_BITS'(vert_x_i);
      vy_q   <= WORD_BITS'(vert_y_i);
      vz_q   <= WORD_BITS'(vert_z_i);
      wsat_q <= 1'b0;
    end
    if (iss) begin
      p_q      <= prod;
      pfirst_q <= (k == 2'd0);
      plast_q  <= (k == 2'd3);
      pfin_q   <= (cnt_q == last_cnt);
      pidx_q   <= cnt_q[5:2];
    end
    if (pv_q) begin
      acc_q  <= (pfirst_q ? acc_t'(0) : acc_q) + ACC_BITS'(p_q);
      aidx_q <= pidx_q;
      afin_q <= pfin_q;
    end
    if (av_q && is_vtx) begin
      case (aidx_q[1:0])
        2'd0:    wx_q <= res;
        2'd1:    wy_q <= res;
        default: wz_q <= res;
      endcase
      if (clamp) begin
        wsat_q <= 1'b1;
      end
    end
    if (push) begin
      ox_q   <= wx_q;
      oy_q   <= wy_q;
      oz_q   <= wz_q;
      osat_q <= wsat_q;
    end
  end

  assign out_valid_o = ov_q;
  assign out_x_o     = FIELD_BITS'(ox_q);
  assign out_y_o     = FIELD_BITS'(oy_q);
  assign out_z_o     = FIELD_BITS'(oz_q);
  assign saturated_o = osat_q;

endmodule

@@ hdl/mcvt_checker.sv @@
// ----------------------------------------------------------------------------
// mcvt_checker: port-level checks for the matrix and vertex unit
// Watches the handshakes and the busy behavior seen at the top-level ports.
// ----------------------------------------------------------------------------
module mcvt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [2:0] operation_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [31:0] out_x_o
);
  import mcvt_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_x_o))
    else $error("stalled output beat changed or vanished");

  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (operation_i == OP_LOAD_CUR || operation_i == OP_LOAD_OPD)
    |=> !in_stall_o)
    else $error("entry load left the block busy");

  a_work_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (operation_i == OP_LEFT || operation_i == OP_RIGHT ||
               operation_i == OP_VERTEX) |=> in_stall_o)
    else $error("multiply or vertex beat did not make the block busy");

  a_out_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("output beat appeared without a vertex in progress");

endmodule

bind matrix_compose_and_vertex_transform mcvt_checker u_mcvt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .operation_i (operation_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_x_o     (out_x_o)
);

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for matrix_compose_and_vertex_transform
// A short table of directed beats covers reset state, field extremes, unused
// operation codes and saturation; random beats follow, built mostly as whole
// matrix loads, composes and vertex runs. A predictor tracks both matrices and
// checks every vertex result, while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
  import mcvt_pkg::*;

  localparam int RAND_ITEMS  = 1900;
  localparam int DIR_N       = 20;
  localparam int MAX_GAP     = 10;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN       = 40;
  localparam int MAX_REPORTS = 50;

  localparam logic [2:0] OP_SPARE_5 = 3'd5;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  typedef logic signed [71:0] wide_t;

  localparam wide_t WIDE_MAX = WORD_MAX;
  localparam wide_t WIDE_MIN = WORD_MIN;
  localparam word_t W0       = '0;
  localparam word_t NEG_ONE  = 32'shFFFF_0000;
  localparam word_t NEG_TWO  = 32'shFFFE_0000;
  localparam word_t TWO      = 32'sh0002_0000;
  localparam word_t THREE_HF = 32'sh0003_8000;
  localparam logic [97:0] NO_RES = '0;

  typedef struct packed {
    logic [2:0] op;
    logic [1:0] row;
    logic [1:0] col;
    word_t      entry;
    word_t      vx;
    word_t      vy;
    word_t      vz;
    logic       typed;
    word_t      ex;
    word_t      ey;
    word_t      ez;
    logic       es;
  } stim_t;

  typedef struct packed {
    word_t x;
    word_t y;
    word_t z;
    logic  sat;
  } vtx_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [2:0]  operation_i;
  logic [1:0]  row_i;
  logic [1:0]  col_i;
  logic signed [FIELD_BITS-1:0] entry_value_i;
  logic signed [FIELD_BITS-1:0] vert_x_i;
  logic signed [FIELD_BITS-1:0] vert_y_i;
  logic signed [FIELD_BITS-1:0] vert_z_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic signed [FIELD_BITS-1:0] out_x_o;
  logic signed [FIELD_BITS-1:0] out_y_o;
  logic signed [FIELD_BITS-1:0] out_z_o;
  logic        saturated_o;

  stim_t    cur_row;
  stim_t    dir_tab [DIR_N];
  stim_t    plan_q [$];
  vtx_res_t vtx_q [$];
  vtx_res_t want;
  word_t    cur_mat [16];
  word_t    opd_mat [16];
  logic     no_gaps;
  int       err_cnt = 0;
  int       quiet_cyc = 0;

  always #5 clk_i = ~clk_i;

  assign operation_i   = cur_row.op;
  assign row_i         = cur_row.row;
  assign col_i         = cur_row.col;
  assign entry_value_i = cur_row.entry;
  assign vert_x_i      = cur_row.vx;
  assign vert_y_i      = cur_row.vy;
  assign vert_z_i      = cur_row.vz;

  matrix_compose_and_vertex_transform DUT (.*);

  function automatic wide_t mulw(input word_t a, input word_t b);
    wide_t wa;
    wide_t wb;
    wa = a;
    wb = b;
    return wa * wb;
  endfunction

  function automatic word_t sat_word(input wide_t s, inout logic hit);
    wide_t q;
    q = s >>> FRAC_BITS;
    if (q > WIDE_MAX) begin
      hit = 1'b1;
      return WORD_MAX;
    end
    if (q < WIDE_MIN) begin
      hit = 1'b1;
      return WORD_MIN;
    end
    return word_t'(q);
  endfunction

  function automatic vtx_res_t transform(input word_t x, input word_t y, input word_t z);
    vtx_res_t r;
    wide_t    s;
    word_t    v [3];
    word_t    o [3];
    logic     hit;
    int       i;
    int       k;
    hit = 1'b0;
    v[0] = x;
    v[1] = y;
    v[2] = z;
    for (i = 0; i < 3; i++) begin
      s = mulw(cur_mat[i*4+3], WORD_ONE);
      for (k = 0; k < 3; k++) s += mulw(cur_mat[i*4+k], v[k]);
      o[i] = sat_word(s, hit);
    end
    r.x = o[0];
    r.y = o[1];
    r.z = o[2];
    r.sat = hit;
    return r;
  endfunction

  task automatic compose(input logic left);
    word_t nxt [16];
    wide_t s;
    logic  hit;
    int    i;
    int    j;
    int    k;
    hit = 1'b0;
    for (i = 0; i < 4; i++) begin
      for (j = 0; j < 4; j++) begin
        s = '0;
        for (k = 0; k < 4; k++) begin
          s += left ? mulw(opd_mat[i*4+k], cur_mat[k*4+j])
                    : mulw(cur_mat[i*4+k], opd_mat[k*4+j]);
        end
        nxt[i*4+j] = sat_word(s, hit);
      end
    end
    for (i = 0; i < 16; i++) cur_mat[i] = nxt[i];
  endtask

  task automatic absorb_beat(input stim_t b);
    case (b.op)
      OP_LOAD_CUR: cur_mat[{b.row, b.col}] = b.entry;
      OP_LOAD_OPD: opd_mat[{b.row, b.col}] = b.entry;
      OP_LEFT:     compose(1'b1);
      OP_RIGHT:    compose(1'b0);
      OP_VERTEX:   vtx_q.push_back(b.typed ? {b.ex, b.ey, b.ez, b.es}
                                           : transform(b.vx, b.vy, b.vz));
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic signed [31:0] exp_v,
                             input logic signed [31:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      err_cnt++;
    end
  endtask

  function automatic word_t rand_word();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return $signed($urandom_range(0, 32'h2_0000)) - 32'sh1_0000;
    if (pick < 80) return $signed($urandom_range(0, 32'h200_0000)) - 32'sh100_0000;
    if (pick < 92) return $urandom;
    case ($urandom_range(0, 4))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return W0;
      3: return '1;
      default: return WORD_ONE;
    endcase
  endfunction

  function automatic stim_t rand_row(input logic [2:0] op);
    stim_t r;
    r = '0;
    r.op = op;
    r.row = 2'($urandom);
    r.col = 2'($urandom);
    r.entry = rand_word();
    r.vx = rand_word();
    r.vy = rand_word();
    r.vz = rand_word();
    return r;
  endfunction

  task automatic plan_group();
    int         pick;
    int         idx;
    stim_t      r;
    logic [2:0] op;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      plan_q.push_back(rand_row(OP_VERTEX));
    end else if (pick < 52) begin
      plan_q.push_back(rand_row(OP_LOAD_CUR));
    end else if (pick < 64) begin
      plan_q.push_back(rand_row(OP_LOAD_OPD));
    end else if (pick < 70) begin
      plan_q.push_back(rand_row($urandom_range(0, 1) ? OP_LEFT : OP_RIGHT));
    end else if (pick < 73) begin
      plan_q.push_back(rand_row(3'($urandom_range(OP_SPARE_5, OP_SPARE_7))));
    end else begin
      op = (pick < 85) ? OP_LOAD_CUR : OP_LOAD_OPD;
      for (idx = 0; idx < 16; idx++) begin
        r = rand_row(op);
        r.row = 2'(idx >> 2);
        r.col = 2'(idx);
        if (r.row == r.col && $urandom_range(0, 1) == 1) r.entry = WORD_ONE;
        plan_q.push_back(r);
      end
      if (op == OP_LOAD_OPD) begin
        plan_q.push_back(rand_row($urandom_range(0, 1) ? OP_LEFT : OP_RIGHT));
      end
      repeat (3) plan_q.push_back(rand_row(OP_VERTEX));
    end
  endtask

  task automatic send(input stim_t r);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cur_row <= r;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (vtx_q.size() == 0) begin
          if (err_cnt < MAX_REPORTS) $error("output beat with no vertex pending");
          err_cnt++;
        end else begin
          want = vtx_q.pop_front();
          check_field("out_x", want.x, out_x_o);
          check_field("out_y", want.y, out_y_o);
          check_field("out_z", want.z, out_z_o);
          check_field("saturated", want.sat, saturated_o);
        end
      end
      if (in_valid_i && !in_stall_o) absorb_beat(cur_row);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cyc <= 0;
      end else if (quiet_cyc >= QUIET_LIMIT) begin
        $display("tb: FAIL");
        $finish;
      end else begin
        quiet_cyc <= quiet_cyc + 1;
      end
    end
  end

  initial begin : out_side
    int n;
    out_stall_i = 1'b0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      n = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
      if (n == 0) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b1;
        do @(posedge clk_i); while (!out_valid_o);
        repeat (n - 1) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin : in_side
    int    i;
    int    sent;
    stim_t row;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    cur_row = '0;
    no_gaps = 1'b0;
    for (i = 0; i < 16; i++) begin
      cur_mat[i] = (i % 5 == 0) ? WORD_ONE : W0;
      opd_mat[i] = W0;
    end
    dir_tab = '{
      {OP_VERTEX, 2'd0, 2'd0, W0, WORD_ONE, NEG_TWO, THREE_HF,
       1'b1, WORD_ONE, NEG_TWO, THREE_HF, 1'b0},
      {OP_VERTEX, 2'd3, 2'd3, WORD_MAX, WORD_MAX, WORD_MIN, W0,
       1'b1, WORD_MAX, WORD_MIN, W0, 1'b0},
      {OP_SPARE_5, 2'd1, 2'd2, WORD_MIN, W0, W0, W0, NO_RES},
      {OP_SPARE_6, 2'd3, 2'd0, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, NO_RES},
      {OP_SPARE_7, 2'd0, 2'd0, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, NO_RES},
      {OP_LOAD_CUR, 2'd0, 2'd3, WORD_MAX, W0, W0, W0, NO_RES},
      {OP_VERTEX, 2'd0, 2'd0, W0, WORD_MAX, W0, W0,
       1'b1, WORD_MAX, W0, W0, 1'b1},
      {OP_LOAD_CUR, 2'd1, 2'd3, WORD_MIN, W0, W0, W0, NO_RES},
      {OP_VERTEX, 2'd0, 2'd0, W0, W0, WORD_MIN, W0,
       1'b1, WORD_MAX, WORD_MIN, W0, 1'b1},
      {OP_LOAD_OPD, 2'd0, 2'd0, TWO, W0, W0, W0, NO_RES},
      {OP_LOAD_OPD, 2'd1, 2'd1, NEG_ONE, W0, W0, W0, NO_RES},
      {OP_LOAD_OPD, 2'd2, 2'd2, WORD_MAX, W0, W0, W0, NO_RES},
      {OP_LOAD_OPD, 2'd3, 2'd3, WORD_MIN, W0, W0, W0, NO_RES},
      {OP_LOAD_OPD, 2'd3, 2'd0, WORD_ONE, W0, W0, W0, NO_RES},
      {OP_LEFT, 2'd0, 2'd0, W0, W0, W0, W0, NO_RES},
      {OP_VERTEX, 2'd0, 2'd0, W0, WORD_ONE, WORD_ONE, WORD_ONE, NO_RES},
      {OP_RIGHT, 2'd0, 2'd0, W0, W0, W0, W0, NO_RES},
      {OP_VERTEX, 2'd0, 2'd0, W0, WORD_MAX, WORD_MIN, NEG_ONE, NO_RES},
      {OP_LOAD_CUR, 2'd2, 2'd2, WORD_MIN, W0, W0, W0, NO_RES},
      {OP_VERTEX, 2'd0, 2'd0, W0, NEG_ONE, NEG_ONE, WORD_MIN, NO_RES}
    };
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (i = 0; i < DIR_N; i++) send(dir_tab[i]);
    sent = 0;
    while (sent < RAND_ITEMS) begin
      if (sent % 150 == 0) no_gaps = ($urandom_range(0, 2) == 0);
      if (plan_q.size() == 0) plan_group();
      row = plan_q.pop_front();
      send(row);
      if (row.op <= OP_VERTEX) sent++;
    end
    in_valid_i <= 1'b0;
    while (vtx_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/mcvt_pkg.sv
hdl/matrix_compose_and_vertex_transform.sv
hdl/mcvt_checker.sv
test/tb.sv
